[src/vbfc_pkg.sv]
`timescale 1ns / 1ps

package vbfc_pkg;

   // coefficient and accumulator widths
   localparam int unsigned COEF_W     = 32;
   localparam int unsigned ACC_W      = 46;
   localparam int unsigned CELL_SHIFT = 4;
   localparam int unsigned NUM_ROWS   = 3;
   localparam int unsigned CSR_IDX_W  = 3;

   // clip bounds, +1.0 and -1.0 in q8.24
   localparam logic signed [ACC_W-1:0] CLIP_ONE     = ACC_W'(64'sd16777216);
   localparam logic signed [ACC_W-1:0] CLIP_NEG_ONE = -CLIP_ONE;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ROW_LO = 3'd0,
      CSR_X_ROW_HI = 3'd1,
      CSR_Y_ROW_LO = 3'd2,
      CSR_Y_ROW_HI = 3'd3,
      CSR_Z_ROW_LO = 3'd4,
      CSR_Z_ROW_HI = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      logic [5:0] cell_z;
      logic [9:0] cell_block;
   } cell_item_type;

   typedef struct packed {
      logic [9:0] req_pos_x;
      logic [9:0] req_pos_y;
      logic [9:0] req_pos_z;
      logic [9:0] req_block;
   } draw_req_type;

endpackage

[src/voxel_block_frustum_cull.sv]
// voxel block frustum cull
//
// req_* carries one world cell per transfer (grid x, y, z and block id).
// rsp_* carries one draw request for each cell that is nonempty, inside the
// world and has at least one cube corner whose clip x, y and z all lie in
// [-1, +1]. cells that fail the test produce no transfer at all.
// csr_* writes the six 64-bit camera row registers (two q8.24 words each);
// csr_ready is always high. rows must only be rewritten while the block is
// drained.
//
// a taken cell passes through the input, per-row base and result registers
// before rsp_valid rises. throughput: one cell every cycle while no stall
// holds the pipeline; the 32x7 row multipliers feed a register, and the
// corner sums and range checks feed the result register.
// when rsp_stall is high the result register holds its transfer; earlier
// stages keep filling bubbles and req_stall only rises once the result and
// base registers hold cells to be delivered and the input register is full.
// reset (synchronous, active high) empties the pipeline and clears the
// camera rows to zero.
`timescale 1ns / 1ps

module voxel_block_frustum_cull #(
   parameter int unsigned WORLD_DIM = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  vbfc_pkg::cell_item_type              req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output vbfc_pkg::draw_req_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vbfc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [2*vbfc_pkg::COEF_W-1:0]        csr_wdata
);

   localparam logic [8:0] WORLD_LIMIT = 9'(WORLD_DIM);

   // camera rows: lo = {y coef, x coef}, hi = {constant, z coef}
   logic [2*vbfc_pkg::COEF_W-1:0] row_lo_ff [vbfc_pkg::NUM_ROWS];
   logic [2*vbfc_pkg::COEF_W-1:0] row_hi_ff [vbfc_pkg::NUM_ROWS];
   logic [2*vbfc_pkg::COEF_W-1:0] row_lo_in [vbfc_pkg::NUM_ROWS];
   logic [2*vbfc_pkg::COEF_W-1:0] row_hi_in [vbfc_pkg::NUM_ROWS];

   // unpacked coefficients per row
   logic signed [vbfc_pkg::COEF_W-1:0] coef_a [vbfc_pkg::NUM_ROWS];
   logic signed [vbfc_pkg::COEF_W-1:0] coef_b [vbfc_pkg::NUM_ROWS];
   logic signed [vbfc_pkg::COEF_W-1:0] coef_c [vbfc_pkg::NUM_ROWS];
   logic signed [vbfc_pkg::COEF_W-1:0] coef_d [vbfc_pkg::NUM_ROWS];

   // input register
   logic                    a_valid_ff, a_valid_in;
   vbfc_pkg::cell_item_type a_item_ff;

   // base register: clip value at the cube origin for each row
   logic                                b_valid_ff, b_valid_in;
   logic signed [vbfc_pkg::ACC_W-1:0]   b_base_ff [vbfc_pkg::NUM_ROWS];
   logic signed [vbfc_pkg::ACC_W-1:0]   b_base_in [vbfc_pkg::NUM_ROWS];
   vbfc_pkg::draw_req_type              b_req_ff, b_req_in;
   logic                                b_hit;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   vbfc_pkg::draw_req_type rsp_data_ff;

   // flow control
   logic rsp_free, b_free, a_free, req_xfer, cell_keep;

   assign csr_ready = 1'b1;

   // csr decode
   always_comb begin
      for (int r = 0; r < vbfc_pkg::NUM_ROWS; r++) begin
         row_lo_in[r] = row_lo_ff[r];
         row_hi_in[r] = row_hi_ff[r];
      end
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vbfc_pkg::CSR_X_ROW_LO: row_lo_in[0] = csr_wdata;
            vbfc_pkg::CSR_X_ROW_HI: row_hi_in[0] = csr_wdata;
            vbfc_pkg::CSR_Y_ROW_LO: row_lo_in[1] = csr_wdata;
            vbfc_pkg::CSR_Y_ROW_HI: row_hi_in[1] = csr_wdata;
            vbfc_pkg::CSR_Z_ROW_LO: row_lo_in[2] = csr_wdata;
            vbfc_pkg::CSR_Z_ROW_HI: row_hi_in[2] = csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < vbfc_pkg::NUM_ROWS; r++) begin
            row_lo_ff[r] <= '0;
            row_hi_ff[r] <= '0;
         end
      end else begin
         for (int r = 0; r < vbfc_pkg::NUM_ROWS; r++) begin
            row_lo_ff[r] <= row_lo_in[r];
            row_hi_ff[r] <= row_hi_in[r];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < vbfc_pkg::NUM_ROWS; r++) begin
         coef_a[r] = $signed(row_lo_ff[r][vbfc_pkg::COEF_W-1:0]);
         coef_b[r] = $signed(row_lo_ff[r][2*vbfc_pkg::COEF_W-1:vbfc_pkg::COEF_W]);
         coef_c[r] = $signed(row_hi_ff[r][vbfc_pkg::COEF_W-1:0]);
         coef_d[r] = $signed(row_hi_ff[r][2*vbfc_pkg::COEF_W-1:vbfc_pkg::COEF_W]);
      end
   end

   // each stage moves when the next one is empty or moving; a cell that
   // failed the corner test simply vanishes from the base stage
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign b_free    = !b_valid_ff || !b_hit || rsp_free;
   assign a_free    = !a_valid_ff || b_free;
   assign req_stall = !a_free;
   assign req_xfer  = req_valid && a_free;

   // empty cells and cells outside the world are dropped on entry
   assign cell_keep = (req_data.cell_block != '0)
                   && ({3'b000, req_data.cell_x} < WORLD_LIMIT)
                   && ({3'b000, req_data.cell_y} < WORLD_LIMIT)
                   && ({3'b000, req_data.cell_z} < WORLD_LIMIT);

   always_comb begin
      if (a_free) begin
         a_valid_in = req_xfer && cell_keep;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_item_ff <= req_data;
      end
   end

   // origin clip value per row: (a*gx + b*gy + c*gz) * 16 + d
   always_comb begin
      logic signed [6:0]  gx_s, gy_s, gz_s;
      logic signed [38:0] prod_x, prod_y, prod_z;
      gx_s = $signed({1'b0, a_item_ff.cell_x});
      gy_s = $signed({1'b0, a_item_ff.cell_y});
      gz_s = $signed({1'b0, a_item_ff.cell_z});
      for (int r = 0; r < vbfc_pkg::NUM_ROWS; r++) begin
         prod_x = coef_a[r] * gx_s;
         prod_y = coef_b[r] * gy_s;
         prod_z = coef_c[r] * gz_s;
         b_base_in[r] = (vbfc_pkg::ACC_W'(prod_x) <<< vbfc_pkg::CELL_SHIFT)
                      + (vbfc_pkg::ACC_W'(prod_y) <<< vbfc_pkg::CELL_SHIFT)
                      + (vbfc_pkg::ACC_W'(prod_z) <<< vbfc_pkg::CELL_SHIFT)
                      + vbfc_pkg::ACC_W'(coef_d[r]);
      end
      b_req_in.req_pos_x = {a_item_ff.cell_x, 4'b0000};
      b_req_in.req_pos_y = {a_item_ff.cell_y, 4'b0000};
      b_req_in.req_pos_z = {a_item_ff.cell_z, 4'b0000};
      b_req_in.req_block = a_item_ff.cell_block;
   end

   always_comb begin
      if (b_free) begin
         b_valid_in = a_valid_ff;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free && a_valid_ff) begin
         b_base_ff <= b_base_in;
         b_req_ff  <= b_req_in;
      end
   end

   // corner test: each corner adds 16*coef on the axes where it sits at the
   // far face of the cube; visible when any corner is inside on all rows
   always_comb begin
      logic [2:0]                        cbits;
      logic signed [vbfc_pkg::ACC_W-1:0] step_a, step_b, step_c, clip_v;
      logic [7:0]                        corner_in;
      corner_in = '1;
      for (int r = 0; r < vbfc_pkg::NUM_ROWS; r++) begin
         step_a = vbfc_pkg::ACC_W'(coef_a[r]) <<< vbfc_pkg::CELL_SHIFT;
         step_b = vbfc_pkg::ACC_W'(coef_b[r]) <<< vbfc_pkg::CELL_SHIFT;
         step_c = vbfc_pkg::ACC_W'(coef_c[r]) <<< vbfc_pkg::CELL_SHIFT;
         for (int c = 0; c < 8; c++) begin
            cbits  = 3'(c);
            clip_v = b_base_ff[r]
                   + (cbits[2] ? step_a : '0)
                   + (cbits[1] ? step_b : '0)
                   + (cbits[0] ? step_c : '0);
            if (clip_v < vbfc_pkg::CLIP_NEG_ONE || clip_v > vbfc_pkg::CLIP_ONE) begin
               corner_in[c] = 1'b0;
            end
         end
      end
      b_hit = |corner_in;
   end

   always_comb begin
      if (rsp_free) begin
         rsp_valid_in = b_valid_ff && b_hit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && b_valid_ff && b_hit) begin
         rsp_data_ff <= b_req_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/vbfc_checker.sv]
`timescale 1ns / 1ps

module vbfc_checker #(
   parameter int unsigned WORLD_DIM = 64
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input vbfc_pkg::draw_req_type rsp_data
);

   localparam logic [12:0] POS_LIMIT = 13'(WORLD_DIM * 16);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled transfer holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transfer changed");

   // empty cells never produce a request
   a_block_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.req_block != '0)
      else $error("request for empty cell");

   // origins are cell aligned and inside the world
   a_pos_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.req_pos_x[3:0] == 4'b0000
                 && rsp_data.req_pos_y[3:0] == 4'b0000
                 && rsp_data.req_pos_z[3:0] == 4'b0000
                 && {3'b000, rsp_data.req_pos_x} < POS_LIMIT
                 && {3'b000, rsp_data.req_pos_y} < POS_LIMIT
                 && {3'b000, rsp_data.req_pos_z} < POS_LIMIT)
      else $error("request origin misaligned or outside world");

endmodule

bind voxel_block_frustum_cull vbfc_checker #(.WORLD_DIM(WORLD_DIM)) u_vbfc_checker (.*);

[verif/voxel_block_frustum_cull_tb.sv]
`timescale 1ns / 1ps

module voxel_block_frustum_cull_tb;

   // run length and pacing
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 8;     // pipeline is 3 deep, round up
   localparam int unsigned HOLD_CYCLES  = 200;   // long receiver hold-off
   localparam int          NUM_PHASES   = 12;
   localparam int          PHASE_ITEMS  = 100;   // nonempty cells per camera setting
   localparam int unsigned WORLD_DIM    = 64;

   // fixed point and geometry
   localparam longint      Q24_ONE   = 64'sd1 << 24;
   localparam longint      CELL_SPAN = 16;

   // indexes past the last camera row, writes there must be dropped
   localparam logic [vbfc_pkg::CSR_IDX_W-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [vbfc_pkg::CSR_IDX_W-1:0] CSR_UNUSED_B = 3'd7;

   // how a directed row is handled
   typedef enum logic [1:0] {
      STEP_CSR,      // register transfer
      STEP_CELL,     // cell checked against the predictor
      STEP_SHOWN,    // cell with its draw request typed in
      STEP_HIDDEN    // cell known to be culled
   } step_kind_type;

   typedef enum logic [1:0] {
      CAM_OPEN,
      CAM_VIEW,
      CAM_SCRAMBLED
   } cam_mode_type;

   typedef struct packed {
      step_kind_type                     kind;
      logic [vbfc_pkg::CSR_IDX_W-1:0]    csr_idx;
      logic [2*vbfc_pkg::COEF_W-1:0]     csr_data;
      vbfc_pkg::cell_item_type           cell_in;
      vbfc_pkg::draw_req_type            typed;
   } cull_step_type;

   // block inputs, all known from time zero
   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   vbfc_pkg::cell_item_type           req_data  = '0;
   logic                              rsp_stall = 1'b0;
   logic                              csr_valid = 1'b0;
   logic [vbfc_pkg::CSR_IDX_W-1:0]    csr_index = vbfc_pkg::CSR_X_ROW_LO;
   logic [2*vbfc_pkg::COEF_W-1:0]     csr_wdata = '0;

   // block outputs
   logic                              req_stall;
   logic                              rsp_valid;
   vbfc_pkg::draw_req_type            rsp_data;
   logic                              csr_ready;

   // shadow of the camera rows, indexed by register index
   logic [2*vbfc_pkg::COEF_W-1:0]     cam_rows [0:5];

   vbfc_pkg::draw_req_type            pending_draws [$];
   cull_step_type                     steps [$];
   int                                mismatches    = 0;
   int unsigned                       cycle_count   = 0;
   bit                                steady_send   = 1'b0;
   bit                                want_hold     = 1'b0;
   bit                                hold_started  = 1'b0;

   voxel_block_frustum_cull #(
      .WORLD_DIM (WORLD_DIM)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // signed q8.24 word widened to 64 bits
   function automatic longint q24(input logic [vbfc_pkg::COEF_W-1:0] w);
      return longint'($signed(w));
   endfunction

   // one clip row: a*cx + b*cy + c*cz + d, exact, inside [-1, +1] inclusive
   function automatic bit clip_in_range(input logic [2*vbfc_pkg::COEF_W-1:0] lo,
                                        input logic [2*vbfc_pkg::COEF_W-1:0] hi,
                                        input longint cx, input longint cy,
                                        input longint cz);
      longint v;
      v = q24(lo[31:0]) * cx + q24(lo[63:32]) * cy
        + q24(hi[31:0]) * cz + q24(hi[63:32]);
      return (v >= -Q24_ONE) && (v <= Q24_ONE);
   endfunction

   // returns 1 when the cell yields a draw request, which lands in drawn
   function automatic bit cull_cell(input vbfc_pkg::cell_item_type c,
                                    output vbfc_pkg::draw_req_type drawn);
      longint ox, oy, oz, cx, cy, cz;
      bit     seen;
      bit     in_world;
      ox   = longint'(c.cell_x) * CELL_SPAN;
      oy   = longint'(c.cell_y) * CELL_SPAN;
      oz   = longint'(c.cell_z) * CELL_SPAN;
      seen = 1'b0;
      in_world = (longint'(c.cell_x) < longint'(WORLD_DIM))
              && (longint'(c.cell_y) < longint'(WORLD_DIM))
              && (longint'(c.cell_z) < longint'(WORLD_DIM));
      // eight cube corners, origin plus 0 or 16 on each axis
      for (int k = 0; k < 8; k++) begin
         cx = ox + (k[2] ? CELL_SPAN : 0);
         cy = oy + (k[1] ? CELL_SPAN : 0);
         cz = oz + (k[0] ? CELL_SPAN : 0);
         if (clip_in_range(cam_rows[vbfc_pkg::CSR_X_ROW_LO],
                           cam_rows[vbfc_pkg::CSR_X_ROW_HI], cx, cy, cz) &&
             clip_in_range(cam_rows[vbfc_pkg::CSR_Y_ROW_LO],
                           cam_rows[vbfc_pkg::CSR_Y_ROW_HI], cx, cy, cz) &&
             clip_in_range(cam_rows[vbfc_pkg::CSR_Z_ROW_LO],
                           cam_rows[vbfc_pkg::CSR_Z_ROW_HI], cx, cy, cz))
            seen = 1'b1;
      end
      drawn.req_pos_x = 10'(ox);
      drawn.req_pos_y = 10'(oy);
      drawn.req_pos_z = 10'(oz);
      drawn.req_block = c.cell_block;
      // empty cells and cells outside the world never draw
      return seen && in_world && (c.cell_block != '0);
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic cull_step_type csr_row(input logic [vbfc_pkg::CSR_IDX_W-1:0] idx,
                                             input logic [2*vbfc_pkg::COEF_W-1:0] data);
      cull_step_type s;
      s          = '0;
      s.kind     = STEP_CSR;
      s.csr_idx  = idx;
      s.csr_data = data;
      return s;
   endfunction

   function automatic cull_step_type cell_row(input step_kind_type kind,
                                              input vbfc_pkg::cell_item_type c,
                                              input vbfc_pkg::draw_req_type typed);
      cull_step_type s;
      s         = '0;
      s.kind    = kind;
      s.cell_in = c;
      s.typed   = typed;
      return s;
   endfunction

   // append one row to the directed table
   function automatic void add_step(input cull_step_type s);
      steps.insert(steps.size(), s);
   endfunction

   // append one expected draw request
   function automatic void expect_draw(input vbfc_pkg::draw_req_type d);
      pending_draws.insert(pending_draws.size(), d);
   endfunction

   // sender idle gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 19));
      if (steady_send || r < 12)
         return 0;
      if (r < 18)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 30));
   endfunction

   // one camera row as {const, z coef, y coef, x coef}
   function automatic logic [4*vbfc_pkg::COEF_W-1:0] make_row(input cam_mode_type mode);
      int w [0:3];
      int mag;
      int axis;
      if (mode == CAM_OPEN)
         return '0;
      if (mode == CAM_SCRAMBLED)
         return {$urandom, $urandom, $urandom, $urandom};
      // a slab along one axis whose half-width is a few hundred voxels,
      // with small cross terms so that slabs are slightly tilted
      mag  = (1 << 24) / int'($urandom_range(96, 640));
      axis = int'($urandom_range(0, 2));
      for (int a = 0; a < 3; a++)
         w[a] = int'($urandom_range(0, mag / 4)) - mag / 8;
      w[axis] = $urandom_range(0, 1) ? mag : -mag;
      w[3]    = -w[axis] * int'($urandom_range(0, 1024))
              + int'($urandom_range(0, 2 * mag)) - mag;
      return {32'(w[3]), 32'(w[2]), 32'(w[1]), 32'(w[0])};
   endfunction

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------

   // wait until every expected draw is out and the no-result cells have left
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_draws.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // only called with the block drained
   task automatic write_csr(input logic [vbfc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [2*vbfc_pkg::COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= vbfc_pkg::CSR_Z_ROW_HI)
         cam_rows[idx] = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_camera(input cam_mode_type mode);
      logic [4*vbfc_pkg::COEF_W-1:0] row;
      drain_pipe();
      row = make_row(mode);
      write_csr(vbfc_pkg::CSR_X_ROW_LO, row[63:0]);
      write_csr(vbfc_pkg::CSR_X_ROW_HI, row[127:64]);
      row = make_row(mode);
      write_csr(vbfc_pkg::CSR_Y_ROW_LO, row[63:0]);
      write_csr(vbfc_pkg::CSR_Y_ROW_HI, row[127:64]);
      row = make_row(mode);
      write_csr(vbfc_pkg::CSR_Z_ROW_LO, row[63:0]);
      write_csr(vbfc_pkg::CSR_Z_ROW_HI, row[127:64]);
      // stray writes to unmapped indexes now and then
      if ($urandom_range(0, 3) == 0)
         write_csr($urandom_range(0, 1) ? CSR_UNUSED_A : CSR_UNUSED_B,
                   {$urandom, $urandom});
   endtask

   // offer one cell, record what it should produce once it is taken
   task automatic send_cell(input vbfc_pkg::cell_item_type cell_in,
                            input step_kind_type kind,
                            input vbfc_pkg::draw_req_type typed);
      vbfc_pkg::draw_req_type drawn;
      int                     gap;
      req_valid <= 1'b1;
      req_data  <= cell_in;
      do @(posedge clock); while (req_stall);
      unique case (kind)
         STEP_SHOWN: expect_draw(typed);
         STEP_CELL: begin
            if (cull_cell(cell_in, drawn))
               expect_draw(drawn);
         end
         default: ;
      endcase
      gap = pick_gap();
      // valid stays up when the next cell follows at once
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      vbfc_pkg::cell_item_type cell_in;
      int                      sent;

      for (int i = 0; i < 6; i++)
         cam_rows[i] = '0;

      // reset camera: all clip values are zero, so every nonempty cell draws
      add_step(cell_row(STEP_SHOWN, {6'd0, 6'd0, 6'd0, 10'd1},
                        {10'd0, 10'd0, 10'd0, 10'd1}));
      add_step(cell_row(STEP_SHOWN, {6'd63, 6'd63, 6'd63, 10'd1023},
                        {10'd1008, 10'd1008, 10'd1008, 10'd1023}));
      add_step(cell_row(STEP_HIDDEN, {6'd5, 6'd9, 6'd33, 10'd0}, '0));
      add_step(cell_row(STEP_SHOWN, {6'd42, 6'd21, 6'd63, 10'd512},
                        {10'd672, 10'd336, 10'd1008, 10'd512}));
      // clip x = cx/16 - 1, near corner of grid x 2 sits exactly on +1
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_LO, 64'h0000_0000_0010_0000));
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_HI, 64'hFF00_0000_0000_0000));
      add_step(cell_row(STEP_CELL, {6'd2, 6'd7, 6'd7, 10'd3}, '0));
      add_step(cell_row(STEP_CELL, {6'd3, 6'd0, 6'd0, 10'd3}, '0));
      // clip x = 1 - cx/16, near corner of grid x 2 sits exactly on -1
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_LO, 64'h0000_0000_FFF0_0000));
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_HI, 64'h0100_0000_0000_0000));
      add_step(cell_row(STEP_CELL, {6'd2, 6'd1, 6'd1, 10'd9}, '0));
      add_step(cell_row(STEP_CELL, {6'd3, 6'd1, 6'd1, 10'd9}, '0));
      // same slope, constant one lsb lower, the -1 corner drops out
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_HI, 64'h00FF_FFFF_0000_0000));
      add_step(cell_row(STEP_CELL, {6'd2, 6'd1, 6'd1, 10'd9}, '0));
      add_step(cell_row(STEP_CELL, {6'd1, 6'd0, 6'd0, 10'd9}, '0));
      // all ones: every word is the smallest negative step
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_LO, '1));
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_HI, '1));
      add_step(csr_row(vbfc_pkg::CSR_Y_ROW_LO, '1));
      add_step(csr_row(vbfc_pkg::CSR_Y_ROW_HI, '1));
      add_step(csr_row(vbfc_pkg::CSR_Z_ROW_LO, '1));
      add_step(csr_row(vbfc_pkg::CSR_Z_ROW_HI, '1));
      add_step(cell_row(STEP_CELL, {6'd63, 6'd63, 6'd63, 10'd1023}, '0));
      add_step(cell_row(STEP_CELL, {6'd0, 6'd0, 6'd0, 10'd1}, '0));
      // unmapped indexes must leave the camera alone
      add_step(csr_row(CSR_UNUSED_A, 64'h7FFF_FFFF_7FFF_FFFF));
      add_step(csr_row(CSR_UNUSED_B, 64'h8000_0000_8000_0000));
      add_step(cell_row(STEP_CELL, {6'd17, 6'd40, 6'd63, 10'd300}, '0));
      // most positive constant, most negative z weight: clip x always out
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_HI, 64'h7FFF_FFFF_8000_0000));
      add_step(cell_row(STEP_CELL, {6'd0, 6'd0, 6'd0, 10'd77}, '0));
      add_step(cell_row(STEP_CELL, {6'd63, 6'd0, 6'd63, 10'd77}, '0));
      // most negative x and y weights in clip y: only cx = cy = 0 corners pass
      add_step(csr_row(vbfc_pkg::CSR_X_ROW_HI, '1));
      add_step(csr_row(vbfc_pkg::CSR_Y_ROW_LO, 64'h8000_0000_8000_0000));
      add_step(cell_row(STEP_CELL, {6'd0, 6'd0, 6'd0, 10'd5}, '0));
      add_step(cell_row(STEP_CELL, {6'd0, 6'd1, 6'd0, 10'd5}, '0));
      add_step(cell_row(STEP_CELL, {6'd0, 6'd0, 6'd63, 10'd5}, '0));
      // most positive weights in clip z: nothing survives
      add_step(csr_row(vbfc_pkg::CSR_Z_ROW_LO, 64'h7FFF_FFFF_7FFF_FFFF));
      add_step(csr_row(vbfc_pkg::CSR_Z_ROW_HI, 64'h7FFF_FFFF_7FFF_FFFF));
      add_step(cell_row(STEP_CELL, {6'd0, 6'd0, 6'd0, 10'd5}, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (steps[i]) begin
         if (steps[i].kind == STEP_CSR) begin
            drain_pipe();
            write_csr(steps[i].csr_idx, steps[i].csr_data);
         end else begin
            send_cell(steps[i].cell_in, steps[i].kind, steps[i].typed);
         end
      end

      // random part, one camera setting per phase
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 0) begin
            // everything draws, receiver holds off so the pipe backs up
            load_camera(CAM_OPEN);
            steady_send = 1'b1;
            want_hold   = 1'b1;
            while (!hold_started)
               @(posedge clock);
         end else begin
            load_camera((phase % 4 == 3) ? CAM_SCRAMBLED : CAM_VIEW);
            steady_send = ($urandom_range(0, 3) == 0);
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            cell_in.cell_x     = 6'($urandom_range(0, 63));
            cell_in.cell_y     = 6'($urandom_range(0, 63));
            cell_in.cell_z     = 6'($urandom_range(0, 63));
            cell_in.cell_block = ($urandom_range(0, 9) == 0) ? 10'd0
                               : 10'($urandom_range(1, 1023));
            send_cell(cell_in, STEP_CELL, '0);
            if (cell_in.cell_block != '0)
               sent++;
         end
      end

      drain_pipe();
      if (mismatches == 0) begin
         $display("voxel_block_frustum_cull test passed");
      end else begin
         $display("voxel_block_frustum_cull test failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // receiver: random stall runs plus one long hold-off on request
   // ---------------------------------------------------------------------------

   initial begin
      int r;
      forever begin
         if (want_hold && !hold_started) begin
            rsp_stall    <= 1'b1;
            hold_started  = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            r = int'($urandom_range(0, 9));
            if (r < 6) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end else if (r < 8) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else if (r == 8) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end else begin
               // long stretch with the receiver always ready
               rsp_stall <= 1'b0;
               repeat ($urandom_range(50, 200)) @(posedge clock);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // draw request checker
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : check_draws
      vbfc_pkg::draw_req_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_draws.size() == 0) begin
            if (mismatches < 10)
               $display("draw request mismatch: expected none, ",
                        "got x=%0d y=%0d z=%0d block=%0d",
                        rsp_data.req_pos_x, rsp_data.req_pos_y,
                        rsp_data.req_pos_z, rsp_data.req_block);
            mismatches++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_data.req_pos_x !== want.req_pos_x ||
                rsp_data.req_pos_y !== want.req_pos_y ||
                rsp_data.req_pos_z !== want.req_pos_z ||
                rsp_data.req_block !== want.req_block) begin
               if (mismatches < 10)
                  $display("draw request mismatch: expected x=%0d y=%0d z=%0d block=%0d,",
                           want.req_pos_x, want.req_pos_y, want.req_pos_z,
                           want.req_block,
                           " got x=%0d y=%0d z=%0d block=%0d",
                           rsp_data.req_pos_x, rsp_data.req_pos_y,
                           rsp_data.req_pos_z, rsp_data.req_block);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("voxel_block_frustum_cull test failed");
         $finish;
      end
   end

endmodule
